// ===== hdl/sm3s_pkg.sv =====
// ============================================================================
// SM3 stream hash package
// Shared types, constants and bit functions of the SM3 stream hash.
// ============================================================================
package sm3s_pkg;

    typedef logic [31:0] word_t;

    localparam int BLOCK_COUNTER_BITS = 32;

    localparam word_t T_LOW   = 32'h79CC4519;
    localparam word_t T_HIGH  = 32'h7A879D8A;
    localparam word_t PAD_WORD = 32'h80000000;

    localparam word_t IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ===== hdl/sm3s_compress.sv =====
// ============================================================================
// SM3 compression unit
// One round per cycle over 64 rounds, with a sliding 16-word expansion window.
// ============================================================================
module sm3s_compress (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sm3s_pkg::word_t  msg    [16],
    input  sm3s_pkg::word_t  cv_in  [8],
    output sm3s_pkg::word_t  cv_out [8],
    output logic             done
);
    import sm3s_pkg::*;

    word_t      v_reg   [8];
    word_t      v_next  [8];
    word_t      win_reg [16];
    word_t      win_next[16];
    logic [5:0] round_reg, round_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;

    word_t a12, tj, ss1, ss2, ff, gg, tt1, tt2, w_new;

    always_comb
    begin
        a12 = rotl(v_reg[0], 5'd12);
        tj  = (round_reg < 6'd16) ? T_LOW : T_HIGH;
        ss1 = rotl(a12 + v_reg[4] + rotl(tj, round_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end
        else
        begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + v_reg[7] + ss1 + win_reg[0];
        w_new = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
              ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];

        v_next     = v_reg;
        win_next   = win_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start)
        begin
            v_next     = cv_in;
            win_next   = msg;
            round_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next[0] = tt1;
            v_next[1] = v_reg[0];
            v_next[2] = rotl(v_reg[1], 5'd9);
            v_next[3] = v_reg[2];
            v_next[4] = perm0(tt2);
            v_next[5] = v_reg[4];
            v_next[6] = rotl(v_reg[5], 5'd19);
            v_next[7] = v_reg[6];
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = w_new;
            round_next   = round_reg + 6'd1;
            if (round_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        win_reg <= win_next;
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cv_out[i] = cv_in[i] ^ v_reg[i];
        end
    end

    assign done = done_reg;

endmodule

// ===== hdl/sm3_stream_hash.sv =====
// ============================================================================
// SM3 stream hash
// Streaming SM3 hash over big-endian 32-bit message words with 256-bit digest.
// ============================================================================
// A word that does not complete a block is taken while the input stays ready; a
// word that completes a block holds the input through the launch, the 64 rounds
// in the shared round unit and the hand-back. A last word adds a padding sweep,
// one or two compressions and eight digest beats. rst_n (async, active low)
// loads the initial value and clears the fill and block counters.
module sm3_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);
    import sm3s_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,  // waiting for a beat
        S_DATA  = 8'b0000_0010,  // compressing a full block, then idle
        S_LBLK  = 8'b0000_0100,  // last word filled the block, compress then pad
        S_SWEEP = 8'b0000_1000,  // writing pad marker and zeros, one word a cycle
        S_PAD1  = 8'b0001_0000,  // first of two padding compressions
        S_LEN   = 8'b0010_0000,  // write the bit length into words 14 and 15
        S_FIN   = 8'b0100_0000,  // final compression
        S_OUT   = 8'b1000_0000   // stream out the eight digest words
    } state_t;

    state_t state_reg, state_next;

    word_t msg_reg [16];
    word_t cv_reg  [8];
    word_t cv_new  [8];

    logic [3:0]  wfill_reg, wfill_next;      // words held in the block buffer
    logic [BLOCK_COUNTER_BITS-1:0] blocks_reg, blocks_next;
    logic [4:0]  sweep_reg, sweep_next;      // sweep word index, 16 ends it
    logic        mark_reg, mark_next;        // pad marker still to be written
    logic        two_reg, two_next;          // padding needs two compressions
    logic [5:0]  pos_reg, pos_next;          // final byte fill of the block
    logic [2:0]  oidx_reg, oidx_next;

    logic        comp_start_reg, comp_start_next, comp_done;
    logic        wr_en, len_wr, cv_load, cv_init;
    logic [3:0]  wr_idx;
    word_t       wr_data;

    logic [2:0]  cnt;
    logic        full_word;
    word_t       keep_mask;
    logic [63:0] bit_len;

    logic s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // Bytes taken from this beat: four unless it is the last word with fewer.
    always_comb
    begin
        if (!s_tlast || s_tdata[34:32] > 3'd4)
            cnt = 3'd4;
        else
            cnt = s_tdata[34:32];
        full_word = (cnt == 3'd4);
        keep_mask = ~(32'hFFFF_FFFF >> {cnt[1:0], 3'b000});
    end

    // Message bit length: blocks counted so far times 512 plus eight times the tail bytes.
    assign bit_len = (64'(blocks_reg) << 9) | 64'({pos_reg, 3'b000});

    always_comb
    begin
        state_next      = state_reg;
        wfill_next      = wfill_reg;
        blocks_next     = blocks_reg;
        sweep_next      = sweep_reg;
        mark_next       = mark_reg;
        two_next        = two_reg;
        pos_next        = pos_reg;
        oidx_next       = oidx_reg;
        comp_start_next = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = wfill_reg;
        wr_data         = s_tdata[31:0];
        len_wr          = 1'b0;
        cv_load         = 1'b0;
        cv_init         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    wr_en = 1'b1;
                    if (!full_word)
                        wr_data = (s_tdata[31:0] & keep_mask)
                                | (PAD_WORD >> {cnt[1:0], 3'b000});
                    wfill_next = wfill_reg + 4'd1;
                    if (s_tlast)
                    begin
                        pos_next   = 6'({wfill_reg, 2'b00} + {3'b000, cnt});
                        two_next   = (6'({wfill_reg, 2'b00} + {3'b000, cnt}) >= 6'd56);
                        mark_next  = full_word;
                        sweep_next = {1'b0, wfill_reg} + 5'd1;
                        if (full_word && wfill_reg == 4'd15)
                        begin
                            comp_start_next = 1'b1;
                            state_next      = S_LBLK;
                        end
                        else
                            state_next = S_SWEEP;
                    end
                    else if (wfill_reg == 4'd15)
                    begin
                        comp_start_next = 1'b1;
                        state_next      = S_DATA;
                    end
                end
            end
            S_DATA:
            begin
                if (comp_done)
                begin
                    cv_load     = 1'b1;
                    blocks_next = blocks_reg + 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_LBLK:
            begin
                if (comp_done)
                begin
                    cv_load     = 1'b1;
                    blocks_next = blocks_reg + 1'b1;
                    sweep_next  = '0;
                    state_next  = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (sweep_reg[4])
                begin
                    if (two_reg)
                    begin
                        comp_start_next = 1'b1;
                        state_next      = S_PAD1;
                    end
                    else
                        state_next = S_LEN;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_idx     = sweep_reg[3:0];
                    wr_data    = mark_reg ? PAD_WORD : '0;
                    mark_next  = 1'b0;
                    sweep_next = sweep_reg + 5'd1;
                end
            end
            S_PAD1:
            begin
                if (comp_done)
                begin
                    cv_load    = 1'b1;
                    two_next   = 1'b0;
                    sweep_next = '0;
                    state_next = S_SWEEP;
                end
            end
            S_LEN:
            begin
                len_wr          = 1'b1;
                comp_start_next = 1'b1;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (comp_done)
                begin
                    cv_load    = 1'b1;
                    oidx_next  = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_acc)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        cv_init     = 1'b1;
                        wfill_next  = '0;
                        blocks_next = '0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The compression is launched in the cycle after it is requested, so the
    // word written in the requesting cycle (last data word or bit length) is
    // already in the buffer when the round unit latches it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wfill_reg      <= '0;
            blocks_reg     <= '0;
            sweep_reg      <= '0;
            mark_reg       <= 1'b0;
            two_reg        <= 1'b0;
            pos_reg        <= '0;
            oidx_reg       <= '0;
            comp_start_reg <= 1'b0;
            cv_reg         <= IV;
        end
        else
        begin
            state_reg      <= state_next;
            wfill_reg      <= wfill_next;
            blocks_reg     <= blocks_next;
            sweep_reg      <= sweep_next;
            mark_reg       <= mark_next;
            two_reg        <= two_next;
            pos_reg        <= pos_next;
            oidx_reg       <= oidx_next;
            comp_start_reg <= comp_start_next;
            if (cv_init)
                cv_reg <= IV;
            else if (cv_load)
                cv_reg <= cv_new;
        end
    end

    // Block buffer.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            msg_reg[wr_idx] <= wr_data;
        if (len_wr)
        begin
            msg_reg[14] <= bit_len[63:32];
            msg_reg[15] <= bit_len[31:0];
        end
    end

    sm3s_compress u_compress (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (comp_start_reg),
        .msg    (msg_reg),
        .cv_in  (cv_reg),
        .cv_out (cv_new),
        .done   (comp_done)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'b00000, oidx_reg, cv_reg[oidx_reg]};
    assign m_tlast  = (oidx_reg == 3'd7);

    // A compression finishes only in a state that waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        comp_done |-> (state_reg == S_DATA || state_reg == S_LBLK ||
                       state_reg == S_PAD1 || state_reg == S_FIN))
        else $error("compression finished outside a compress state");

    // Input is never taken while digest beats are pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while digest is streaming");

    // After the eighth digest beat the block is back to accepting input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && m_tlast) |=> (s_tready && wfill_reg == 4'd0))
        else $error("block did not return to idle after digest");

endmodule
